// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the voxel fusion block.
// Uses the clk and arst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TVF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TVF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TVF_ASSERT(lbl, prop, msg)
`define TVF_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/tvf_pkg.sv -----
// Types and constants of the voxel fusion block.
// No dependencies; imported by every module of the block.
package tvf_pkg;

	localparam int IDX_W    = 18;
	localparam int IDX_SPAN = 2 ** IDX_W;
	localparam int TRUNC_W  = 10;
	localparam int SDF_W    = 18;
	localparam int Q1_W     = 15;
	localparam int N1_W     = TRUNC_W + Q1_W;
	localparam int D1_W     = TRUNC_W + 1;
	localparam int Q2_W     = 15;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	localparam logic [1:0] OP_FUSE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_FUSED   = 3'd0;
	localparam logic [2:0] ST_BEHIND  = 3'd1;
	localparam logic [2:0] ST_RANGE   = 3'd2;
	localparam logic [2:0] ST_TRUNC   = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic [1:0] CFG_TRUNC = 2'd0;
	localparam logic [1:0] CFG_MAXW  = 2'd1;
	localparam logic [1:0] CFG_MIND  = 2'd2;
	localparam logic [1:0] CFG_MAXD  = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [IDX_W-1:0]  voxel_index;
		logic signed [15:0] voxel_cam_z_mm;
		logic [15:0]       measured_depth_mm;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [15:0] tsdf_value;
		logic [7:0]         weight_value;
		logic               sample_clamped;
	} rsp_t;

endpackage

// ----- rtl/tvf_store.sv -----
// Voxel store: single write, single registered read, and the clearing
// pass that fills every entry with the empty value after reset.
module tvf_store import tvf_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int AW = 9,
	parameter int DW = 24,
	parameter logic [DW-1:0] INIT = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic          busy
);

	logic [DW-1:0] mem [DEPTH];
	logic          busy_q;
	logic [AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + AW'(1);
			if (cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[cnt_q] <= INIT;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

// ----- rtl/tvf_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires num >> QW < den; exposes every stage for hazard checks.
module tvf_div_pipe import tvf_pkg::*; #(
	parameter int NW = 25,
	parameter int DW = 11,
	parameter int QW = 14,
	parameter int SW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [NW-1:0]          num,
	input  logic [DW-1:0]          den,
	input  logic [SW-1:0]          side,
	output logic                   out_vld,
	output logic [QW-1:0]          quo,
	output logic [SW-1:0]          out_side,
	output logic [QW-1:0]          stage_vld,
	output logic [QW-1:0][SW-1:0]  stage_side
);

	logic [QW-1:0]       vld_s;
	logic [DW+QW-1:0]    acc_s [QW];
	logic [DW-1:0]       den_s [QW];
	logic [SW-1:0]       side_s [QW];
	logic [DW+QW-1:0]    acc_src [QW];
	logic [DW-1:0]       den_src [QW];
	logic [SW-1:0]       side_src [QW];
	logic [DW+QW-1:0]    acc_nxt [QW];

	assign acc_src[0]  = {DW'(num[NW-1:QW]), num[QW-1:0]};
	assign den_src[0]  = den;
	assign side_src[0] = side;

	for (genvar k = 1; k < QW; k++) begin : g_src
		assign acc_src[k]  = acc_s[k-1];
		assign den_src[k]  = den_s[k-1];
		assign side_src[k] = side_s[k-1];
	end

	always_comb begin
		logic [DW:0] t;
		logic [DW:0] td;
		logic        ge;
		for (int k = 0; k < QW; k++) begin
			t  = acc_src[k][DW+QW-1:QW-1];
			td = t - {1'b0, den_src[k]};
			ge = (t >= {1'b0, den_src[k]});
			acc_nxt[k] = {(ge ? td[DW-1:0] : t[DW-1:0]), acc_src[k][QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				acc_s[k]  <= acc_nxt[k];
				den_s[k]  <= den_src[k];
				side_s[k] <= side_src[k];
			end
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_tap
		assign stage_side[k] = side_s[k];
	end

	assign stage_vld = vld_s;
	assign out_vld   = vld_s[QW-1];
	assign quo       = acc_s[QW-1][QW-1:0];
	assign out_side  = side_s[QW-1];

endmodule

// ----- rtl/tsdf_voxel_fusion_top.sv -----
// Top level of the voxel fusion block: decode, two divider pipelines,
// multiply and accumulate stages, voxel store. Uses tvf_pkg, tvf_store, tvf_div_pipe.
//
// One request word enters per cycle and its response word leaves through the response
// register at the end of the pipe; the throughput is one word per cycle as long as
// consecutive updates touch different voxels and rsp_stall is low. A word whose voxel
// is still being updated further down the pipe (a fuse or clear in flight) is held at
// the input until that update is written back; the wait is set by the read-modify-write
// loop through the two divider pipelines (15 stages each). After reset the store is swept
// to +1.0 and weight 0, one entry per cycle, min(RES^3, 262144) entries in all (262144
// at the default RES), and no request is taken during the sweep.
// Configuration registers may be written at any time but only take
// defined effect while the pipe is empty.
`include "assert_macros.svh"
module tsdf_voxel_fusion_top import tvf_pkg::*; #(
	parameter int RES = 64,
	parameter int WEIGHT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int NVOX  = RES * RES * RES;
	localparam int DEPTH = (NVOX < IDX_SPAN) ? NVOX : IDX_SPAN;
	localparam int AW    = $clog2(DEPTH);
	localparam int WB    = WEIGHT_BITS;
	localparam int MW    = 16 + WB;
	localparam int CW    = (WB + 1 > 8) ? WB + 1 : 8;
	localparam int WX    = (WB > 8) ? WB : 8;
	localparam int N2_W  = WB + 16;
	localparam int D2_W  = WB + 2;
	localparam int P_W   = WB + 17;
	localparam int S_W   = WB + 18;

	typedef struct packed {
		logic [2:0]         status;
		logic               clamped;
		logic [IDX_W-1:0]   idx;
		logic               inrange;
		logic               we;
		logic signed [15:0] tsdf;
		logic [WB-1:0]      w;
	} meta_t;

	typedef struct packed {
		logic  sgn;
		meta_t m;
	} dside_t;

	localparam int SW = $bits(dside_t);

	logic [TRUNC_W-1:0] trunc_q;
	logic [7:0]         maxw_q;
	logic [15:0]        mind_q;
	logic [15:0]        maxd_q;

	logic adv;
	logic acc_req;
	logic hazard;
	logic st_busy;
	logic [MW-1:0] rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;
	logic [TRUNC_W-1:0] tr;

	req_t  req_s1;
	logic  vld_s1;
	meta_t meta_c;
	logic signed [SDF_W-1:0] sdf_c;

	logic  vld_s2;
	meta_t meta_s2;
	logic signed [SDF_W-1:0] sdf_s2;
	logic [SDF_W-1:0]   magw1;
	logic [TRUNC_W-1:0] mag1;
	logic [N1_W-1:0]    num1;
	logic [D1_W-1:0]    den1;
	dside_t             side1;

	logic               d1_vld;
	logic [Q1_W-1:0]    d1_quo;
	logic [SW-1:0]      d1_side;
	logic [Q1_W-1:0]    d1_stage_vld;
	logic [Q1_W-1:0][SW-1:0] d1_stage_side;
	dside_t             d1s;
	logic signed [15:0] q_c;

	logic               vld_s3;
	meta_t              meta_s3;
	logic signed [15:0] q_s3;
	logic signed [P_W-1:0] p_s3;

	logic               vld_s4;
	meta_t              meta_s4;
	logic signed [S_W-1:0] sum_s4;
	logic [S_W-1:0]     magw2;
	logic [N2_W-1:0]    num2;
	logic [D2_W-1:0]    den2;
	dside_t             side2;

	logic               d2_vld;
	logic [Q2_W-1:0]    d2_quo;
	logic [SW-1:0]      d2_side;
	logic [Q2_W-1:0]    d2_stage_vld;
	logic [Q2_W-1:0][SW-1:0] d2_stage_side;
	dside_t             d2s;
	logic signed [15:0] avg;
	logic [CW-1:0]      wp1;
	logic [CW-1:0]      lim;
	logic [CW-1:0]      wn_c;
	logic               fw;
	logic signed [15:0] tsdf_o;
	logic [WB-1:0]      w_o;
	rsp_t               rsp_c;

	rsp_t rsp_q;
	logic rsp_vld_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_q <= TRUNC_W'(30);
			maxw_q  <= 8'd100;
			mind_q  <= 16'd300;
			maxd_q  <= 16'd4000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TRUNC: trunc_q <= cfg_data[TRUNC_W-1:0];
				CFG_MAXW:  maxw_q  <= cfg_data[7:0];
				CFG_MIND:  mind_q  <= cfg_data;
				CFG_MAXD:  maxd_q  <= cfg_data;
				default:   trunc_q <= trunc_q;
			endcase
		end
	end

	assign tr = (trunc_q == '0) ? TRUNC_W'(1) : trunc_q;

	// flow control
	assign adv       = !rsp_vld_q || !rsp_stall;
	assign req_stall = st_busy || !adv || hazard;
	assign acc_req   = req_valid && !req_stall;

	always_comb begin
		dside_t h;
		hazard = 1'b0;
		if (vld_s1 && (req_s1.operation == OP_FUSE || req_s1.operation == OP_CLEAR)
				&& req_s1.voxel_index == req.voxel_index) begin
			hazard = 1'b1;
		end
		if (vld_s2 && meta_s2.we && meta_s2.idx == req.voxel_index) begin
			hazard = 1'b1;
		end
		if (vld_s3 && meta_s3.we && meta_s3.idx == req.voxel_index) begin
			hazard = 1'b1;
		end
		if (vld_s4 && meta_s4.we && meta_s4.idx == req.voxel_index) begin
			hazard = 1'b1;
		end
		for (int k = 0; k < Q1_W; k++) begin
			h = dside_t'(d1_stage_side[k]);
			if (d1_stage_vld[k] && h.m.we && h.m.idx == req.voxel_index) begin
				hazard = 1'b1;
			end
		end
		for (int k = 0; k < Q2_W; k++) begin
			h = dside_t'(d2_stage_side[k]);
			if (d2_stage_vld[k] && h.m.we && h.m.idx == req.voxel_index) begin
				hazard = 1'b1;
			end
		end
	end

	tvf_store #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (MW),
		.INIT (MW'({ONE_Q14, {WB{1'b0}}}))
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (adv),
		.rd_addr(req.voxel_index[AW-1:0]),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.busy   (st_busy)
	);

	// stage 1: request word and store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc_req;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
		end
	end

	// decode
	always_comb begin
		logic signed [SDF_W-1:0] trs;
		logic [2:0] st;
		trs   = $signed({{(SDF_W - TRUNC_W){1'b0}}, tr});
		sdf_c = $signed({2'b00, req_s1.measured_depth_mm})
			- $signed({{2{req_s1.voxel_cam_z_mm[15]}}, req_s1.voxel_cam_z_mm});
		meta_c.inrange = ({1'b0, req_s1.voxel_index} < (IDX_W + 1)'(DEPTH));
		meta_c.idx     = req_s1.voxel_index;
		case (req_s1.operation)
			OP_CLEAR: st = ST_CLEARED;
			OP_FUSE: begin
				if ($signed(req_s1.voxel_cam_z_mm) <= 16'sd0) begin
					st = ST_BEHIND;
				end else if (req_s1.measured_depth_mm < mind_q
						|| req_s1.measured_depth_mm > maxd_q) begin
					st = ST_RANGE;
				end else if (sdf_c < -trs) begin
					st = ST_TRUNC;
				end else begin
					st = ST_FUSED;
				end
			end
			default: st = ST_READ;
		endcase
		meta_c.status  = st;
		meta_c.clamped = (st == ST_FUSED) && (sdf_c >= trs);
		meta_c.we      = meta_c.inrange && (st == ST_FUSED || st == ST_CLEARED);
		if (st == ST_CLEARED || !meta_c.inrange) begin
			meta_c.tsdf = ONE_Q14;
			meta_c.w    = '0;
		end else begin
			meta_c.tsdf = $signed(rd_data[MW-1:WB]);
			meta_c.w    = rd_data[WB-1:0];
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_c;
			sdf_s2  <= sdf_c;
		end
	end

	assign magw1 = sdf_s2[SDF_W-1] ? SDF_W'(-sdf_s2) : SDF_W'(sdf_s2);
	assign mag1  = (meta_s2.status == ST_FUSED && !meta_s2.clamped) ?
		magw1[TRUNC_W-1:0] : '0;
	assign num1  = {mag1, {Q1_W{1'b0}}} + N1_W'(tr);
	assign den1  = {tr, 1'b0};
	assign side1 = '{sgn: sdf_s2[SDF_W-1], m: meta_s2};

	tvf_div_pipe #(
		.NW(N1_W),
		.DW(D1_W),
		.QW(Q1_W),
		.SW(SW)
	) u_div_sample (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_vld    (vld_s2),
		.num       (num1),
		.den       (den1),
		.side      (SW'(side1)),
		.out_vld   (d1_vld),
		.quo       (d1_quo),
		.out_side  (d1_side),
		.stage_vld (d1_stage_vld),
		.stage_side(d1_stage_side)
	);

	assign d1s = dside_t'(d1_side);

	always_comb begin
		if (d1s.m.status != ST_FUSED) begin
			q_c = '0;
		end else if (d1s.m.clamped) begin
			q_c = ONE_Q14;
		end else if (d1s.sgn) begin
			q_c = -$signed({1'b0, d1_quo});
		end else begin
			q_c = $signed({1'b0, d1_quo});
		end
	end

	// stage 3: new sample and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= d1s.m;
			q_s3    <= q_c;
			p_s3    <= P_W'(d1s.m.tsdf) * P_W'($signed({1'b0, d1s.m.w}));
		end
	end

	// stage 4: weighted sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta_s3;
			sum_s4  <= S_W'(p_s3) + S_W'(q_s3);
		end
	end

	assign magw2 = sum_s4[S_W-1] ? S_W'(-sum_s4) : S_W'(sum_s4);
	assign num2  = {magw2[WB+14:0], 1'b0} + N2_W'(meta_s4.w) + N2_W'(1);
	assign den2  = {(WB + 1)'(meta_s4.w) + (WB + 1)'(1), 1'b0};
	assign side2 = '{sgn: sum_s4[S_W-1], m: meta_s4};

	tvf_div_pipe #(
		.NW(N2_W),
		.DW(D2_W),
		.QW(Q2_W),
		.SW(SW)
	) u_div_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_vld    (vld_s4),
		.num       (num2),
		.den       (den2),
		.side      (SW'(side2)),
		.out_vld   (d2_vld),
		.quo       (d2_quo),
		.out_side  (d2_side),
		.stage_vld (d2_stage_vld),
		.stage_side(d2_stage_side)
	);

	assign d2s = dside_t'(d2_side);

	// write back and response
	always_comb begin
		avg  = d2s.sgn ? -$signed({1'b0, d2_quo}) : $signed({1'b0, d2_quo});
		wp1  = CW'(d2s.m.w) + CW'(1);
		lim  = (CW'(maxw_q) < CW'({WB{1'b1}})) ? CW'(maxw_q) : CW'({WB{1'b1}});
		wn_c = (wp1 > lim) ? lim : wp1;
		fw   = (d2s.m.status == ST_FUSED) && d2s.m.inrange;
		tsdf_o = fw ? avg : d2s.m.tsdf;
		w_o    = fw ? wn_c[WB-1:0] : d2s.m.w;
		rsp_c.status         = d2s.m.status;
		rsp_c.tsdf_value     = tsdf_o;
		rsp_c.weight_value   = 8'(WX'(w_o));
		rsp_c.sample_clamped = d2s.m.clamped;
	end

	assign wr_en   = adv && d2_vld && d2s.m.we;
	assign wr_addr = d2s.m.idx[AW-1:0];
	assign wr_data = {tsdf_o, w_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	`TVF_NEVER(a_wr_busy, st_busy && wr_en, "store write during clearing pass")
	`TVF_ASSERT(a_acc_s1, acc_req |=> vld_s1, "accepted word missing from stage 1")
	`TVF_ASSERT(a_avg_rng, (d2_vld && d2s.m.status == ST_FUSED) |-> (d2_quo <= 15'd16384), "average out of range")
	`TVF_ASSERT(a_clr_rsp, (rsp_vld_q && rsp_q.status == ST_CLEARED) |-> (rsp_q.weight_value == 8'd0 && rsp_q.tsdf_value == ONE_Q14), "cleared voxel not empty")

endmodule

// ----- tb/tsdf_voxel_fusion_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tsdf_voxel_fusion_top: a directed table, then random fuse/read/clear
// words across several register settings, each checked against a built-in voxel fusion model.
// Depends on tvf_pkg and the RTL of the block only.
module tsdf_voxel_fusion_top_test;
	import tvf_pkg::*;

	typedef struct {
		req_t word;
		bit   typed;
		rsp_t rsp;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [9:0]  trunc_reg;
	logic [7:0]  maxw_reg;
	logic [15:0] mind_reg;
	logic [15:0] maxd_reg;
	logic signed [15:0] dist_mem [int];
	logic [7:0]  wt_mem [int];
	rsp_t        pending_rsp[$];
	int          fail_cnt;
	int          sent_cnt;
	int          idle_cycles;
	int          idle_mode;
	logic [17:0] voxel_pool [16];

	tsdf_voxel_fusion_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint div_nearest(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic rsp_t fuse_voxel(req_t w);
		rsp_t   r;
		int     idx;
		longint dval;
		longint tr;
		longint sdf;
		longint q;
		int     wt;
		int     wn;
		idx = w.voxel_index;
		dval = dist_mem.exists(idx) ? longint'(dist_mem[idx]) : longint'(ONE_Q14);
		wt = wt_mem.exists(idx) ? int'(wt_mem[idx]) : 0;
		r.sample_clamped = 1'b0;
		if (w.operation == OP_CLEAR) begin
			r.status = ST_CLEARED;
			dval = ONE_Q14;
			wt = 0;
			dist_mem[idx] = ONE_Q14;
			wt_mem[idx] = 8'd0;
		end else if (w.operation != OP_FUSE) begin
			r.status = ST_READ;
		end else if (w.voxel_cam_z_mm <= 0) begin
			r.status = ST_BEHIND;
		end else if (w.measured_depth_mm < mind_reg || w.measured_depth_mm > maxd_reg) begin
			r.status = ST_RANGE;
		end else begin
			tr = (trunc_reg == 0) ? 1 : longint'(trunc_reg);
			sdf = longint'(w.measured_depth_mm) - longint'(w.voxel_cam_z_mm);
			if (sdf < -tr) begin
				r.status = ST_TRUNC;
			end else begin
				r.status = ST_FUSED;
				if (sdf >= tr) begin
					q = ONE_Q14;
					r.sample_clamped = 1'b1;
				end else begin
					q = div_nearest(sdf * 16384, tr);
				end
				dval = div_nearest(dval * wt + q, wt + 1);
				wn = wt + 1;
				if (wn > maxw_reg) wn = maxw_reg;
				if (wn > 255) wn = 255;
				wt = wn;
				dist_mem[idx] = dval[15:0];
				wt_mem[idx] = wt[7:0];
			end
		end
		r.tsdf_value = dval[15:0];
		r.weight_value = wt[7:0];
		return r;
	endfunction

	function automatic req_t next_fusion_word();
		req_t w;
		int   sel;
		int   tr;
		int   meas;
		int   cz;
		sel = $urandom_range(99);
		w.operation = OP_FUSE;
		w.voxel_index = voxel_pool[$urandom_range(15)];
		w.voxel_cam_z_mm = 16'($urandom);
		w.measured_depth_mm = 16'($urandom);
		if (sel < 10) begin
			w.operation = 2'($urandom);
			w.voxel_index = 18'($urandom);
		end else if (sel < 22) begin
			w.operation = 2'($urandom_range(3, 1));
		end else if (sel < 85 && mind_reg <= maxd_reg) begin
			tr = (trunc_reg == 0) ? 1 : trunc_reg;
			meas = $urandom_range(maxd_reg, mind_reg);
			if ($urandom_range(9) == 0) meas = ($urandom_range(1)) ? mind_reg - 1 : maxd_reg + 1;
			cz = meas - ($urandom_range(2 * tr + 4) - tr - 2);
			if (cz > 32767) cz = 32767;
			if (cz < -32768) cz = -32768;
			w.measured_depth_mm = 16'(meas);
			w.voxel_cam_z_mm = 16'(cz);
		end
		return w;
	endfunction

	task automatic send_word(req_t w, bit typed, rsp_t typed_rsp);
		rsp_t p;
		while ($urandom_range(99) < ((idle_mode == 0) ? 17 : (idle_mode == 1) ? 59 : 0)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		p = fuse_voxel(w);
		pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : p);
		sent_cnt++;
		idle_mode = (sent_cnt < 650) ? 0 : (sent_cnt < 1300) ? 1 : 2;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_TRUNC: trunc_reg = value[9:0];
			CFG_MAXW:  maxw_reg = value[7:0];
			CFG_MIND:  mind_reg = value;
			CFG_MAXD:  maxd_reg = value;
			default:   ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < ((idle_mode == 0) ? 59 : (idle_mode == 1) ? 17 : 0));
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing expected");
				fail_cnt++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					fail_cnt++;
				end
				if (rsp.tsdf_value !== e.tsdf_value) begin
					$error("tsdf_value expected %0d actual %0d", e.tsdf_value, rsp.tsdf_value);
					fail_cnt++;
				end
				if (rsp.weight_value !== e.weight_value) begin
					$error("weight_value expected %0d actual %0d", e.weight_value,
						rsp.weight_value);
					fail_cnt++;
				end
				if (rsp.sample_clamped !== e.sample_clamped) begin
					$error("sample_clamped expected %0d actual %0d",
						e.sample_clamped, rsp.sample_clamped);
					fail_cnt++;
				end
			end
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 1000000) begin
			$display("tsdf_voxel_fusion_top verification failed");
			$finish;
		end
	end

	function automatic table_row_t row(logic [1:0] op, int idx, int cz, int meas, bit typed,
			logic [2:0] st, int dv, int wt, bit clamp);
		table_row_t t;
		t.word.operation = op;
		t.word.voxel_index = 18'(idx);
		t.word.voxel_cam_z_mm = 16'(cz);
		t.word.measured_depth_mm = 16'(meas);
		t.typed = typed;
		t.rsp.status = st;
		t.rsp.tsdf_value = 16'(dv);
		t.rsp.weight_value = 8'(wt);
		t.rsp.sample_clamped = clamp;
		return t;
	endfunction

	initial begin
		table_row_t  directed [18];
		logic [15:0] settings [6][4];
		int          ph;
		int          k;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TRUNC;
		cfg_data = '0;
		fail_cnt = 0;
		sent_cnt = 0;
		idle_cycles = 0;
		idle_mode = 0;
		trunc_reg = 10'd30;
		maxw_reg = 8'd100;
		mind_reg = 16'd300;
		maxd_reg = 16'd4000;
		foreach (voxel_pool[i]) voxel_pool[i] = 18'($urandom);
		voxel_pool[0] = 18'd0;
		voxel_pool[1] = 18'h3FFFF;
		settings = '{'{30, 100, 300, 4000}, '{1, 1, 0, 65535}, '{1023, 255, 0, 65535},
			'{0, 0, 100, 200}, '{500, 3, 5000, 1000}, '{64, 20, 300, 8000}};

		directed[0]  = row(OP_READ, 0, 0, 0, 1, ST_READ, 16384, 0, 0);
		directed[1]  = row(2'd3, 262143, 5, 5, 1, ST_READ, 16384, 0, 0);
		directed[2]  = row(OP_FUSE, 5, 0, 1000, 1, ST_BEHIND, 16384, 0, 0);
		directed[3]  = row(OP_FUSE, 5, -32768, 1000, 1, ST_BEHIND, 16384, 0, 0);
		directed[4]  = row(OP_FUSE, 5, 1000, 299, 1, ST_RANGE, 16384, 0, 0);
		directed[5]  = row(OP_FUSE, 5, 1000, 4001, 1, ST_RANGE, 16384, 0, 0);
		directed[6]  = row(OP_FUSE, 5, 1000, 969, 1, ST_TRUNC, 16384, 0, 0);
		directed[7]  = row(OP_FUSE, 5, 1000, 1030, 1, ST_FUSED, 16384, 1, 1);
		directed[8]  = row(OP_FUSE, 5, 1000, 970, 1, ST_FUSED, 0, 2, 0);
		directed[9]  = row(OP_FUSE, 5, 1000, 1015, 0, ST_FUSED, 0, 0, 0);
		directed[10] = row(OP_FUSE, 6, 32767, 65535, 1, ST_RANGE, 16384, 0, 0);
		directed[11] = row(OP_FUSE, 6, 300, 300, 1, ST_FUSED, 0, 1, 0);
		directed[12] = row(OP_FUSE, 6, 3999, 4000, 0, ST_FUSED, 0, 0, 0);
		directed[13] = row(OP_CLEAR, 5, 0, 0, 1, ST_CLEARED, 16384, 0, 0);
		directed[14] = row(OP_READ, 5, 0, 0, 1, ST_READ, 16384, 0, 0);
		directed[15] = row(OP_FUSE, 262143, 1, 300, 1, ST_FUSED, 16384, 1, 1);
		directed[16] = row(OP_READ, 262143, 0, 0, 1, ST_READ, 16384, 1, 0);
		directed[17] = row(OP_FUSE, 6, 310, 301, 0, ST_FUSED, 0, 0, 0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].rsp);
		for (ph = 0; ph < 6; ph++) begin
			drain_pipe();
			if (ph > 0) begin
				for (k = 0; k < 4; k++) write_reg(k[1:0], settings[ph][k]);
				cfg_valid <= 1'b0;
			end
			repeat (322) send_word(next_fusion_word(), 1'b0, '0);
		end
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("tsdf_voxel_fusion_top verification clean");
		else
			$display("tsdf_voxel_fusion_top verification failed");
		$finish;
	end
endmodule

// ----- tsdf_voxel_fusion_top.f -----
+incdir+rtl
rtl/tvf_pkg.sv
rtl/tvf_store.sv
rtl/tvf_div_pipe.sv
rtl/tsdf_voxel_fusion_top.sv
tb/tsdf_voxel_fusion_top_test.sv
